// ----- hw/rtl/swiglu_pkg.sv -----
// shared types, constants and elaboration-time sigmoid table math for the swiglu unit
package swiglu_pkg;

    // total register stages from input item to output register
    localparam int PIPE_DEPTH = 9;

    // fixed point used while building the sigmoid table
    localparam int              QS       = 28;
    localparam longint unsigned Q_ONE    = 64'd1 << QS;
    localparam longint unsigned Q_MASK   = Q_ONE - 64'd1;
    localparam longint unsigned Q_EULER  = 64'd729683222;
    localparam longint unsigned X_CUTOFF = 64'd20;

    // sign flags that travel with an item
    typedef struct packed {
        logic gate_neg;
        logic res_neg;
    } sign_flags_t;

    // shift-subtract division, returns {quotient, remainder}
    function automatic logic [127:0] udivmod(input longint unsigned a,
                                             input longint unsigned b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], a[k]};
            if (r >= b) begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return {q, r};
    endfunction

    // (a * b) >> QS, truncated
    function automatic longint unsigned qmul(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned hi;
        longint unsigned lo;
        hi = a >> QS;
        lo = a & Q_MASK;
        return hi * b + ((lo * b) >> QS);
    endfunction

    // one sigmoid table point in unsigned Q.fb
    function automatic longint unsigned sigmoid_point(input int unsigned i,
                                                      input int unsigned dw,
                                                      input int unsigned fb,
                                                      input int unsigned depth);
        longint unsigned num;
        longint unsigned den;
        longint unsigned whole;
        longint unsigned rem;
        longint unsigned f;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned e;
        longint unsigned d;
        longint unsigned inv;
        logic [127:0]    qr;
        num   = longint'(i) << (dw - 1);
        den   = longint'(depth) << fb;
        qr    = udivmod(num, den);
        whole = qr[127:64];
        rem   = qr[63:0];
        if (whole >= X_CUTOFF) begin
            return 64'd1 << fb;
        end
        // fraction of x in Q.28
        f = '0;
        for (int k = 0; k < QS; k++) begin
            rem = rem << 1;
            f   = f << 1;
            if (rem >= den) begin
                rem = rem - den;
                f   = f | 64'd1;
            end
        end
        // series for e^f
        term = Q_ONE;
        sum  = Q_ONE;
        for (int n = 1; n <= 16; n++) begin
            qr   = udivmod(qmul(term, f), longint'(n));
            term = qr[127:64];
            sum  = sum + term;
        end
        // whole units of e
        e = sum;
        for (longint unsigned k = 0; k < whole; k++) begin
            e = qmul(e, Q_EULER);
        end
        d   = Q_ONE + e;
        qr  = udivmod((64'd1 << (fb + QS)) + (d >> 1), d);
        inv = qr[127:64];
        return (64'd1 << fb) - inv;
    endfunction

endpackage

// ----- hw/rtl/swiglu_sigmoid.sv -----
// magnitude, table lookup and interpolation stages that form sigmoid of the gate
module swiglu_sigmoid #(
    parameter int DATA_WIDTH        = 16,
    parameter int FRAC_BITS         = 12,
    parameter int SIGMOID_LUT_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [DATA_WIDTH-1:0]  gate,
    input  logic signed [DATA_WIDTH-1:0]  up,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DATA_WIDTH-1:0]         mag_gate,
    output logic [DATA_WIDTH-1:0]         mag_up,
    output logic [FRAC_BITS:0]            sig,
    output swiglu_pkg::sign_flags_t       flags
);

    localparam int DW       = DATA_WIDTH;
    localparam int FB       = FRAC_BITS;
    localparam int DEPTH    = SIGMOID_LUT_DEPTH;
    localparam int SW       = FB + 1;
    localparam int IW       = $clog2(DEPTH + 1);
    localparam int PW       = DW - 1 + IW;
    localparam int IPW      = SW + DW - 1;
    localparam int TBL_BITS = (DEPTH + 1) * SW;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH);
    localparam logic [SW-1:0] SIG_ONE  = SW'(1) << FB;

    // sigmoid table, non-decreasing, built at elaboration
    function automatic logic [TBL_BITS-1:0] build_table();
        logic [TBL_BITS-1:0] t;
        longint unsigned     v;
        longint unsigned     prev;
        t    = '0;
        prev = '0;
        for (int i = 0; i <= DEPTH; i++) begin
            v = swiglu_pkg::sigmoid_point(i, DW, FB, DEPTH);
            if (i > 0 && v < prev) begin
                v = prev;
            end
            t[i*SW +: SW] = SW'(v);
            prev = v;
        end
        return t;
    endfunction

    localparam logic [TBL_BITS-1:0] SIG_TABLE = build_table();

    // stage registers
    logic                    v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DW-1:0]           mg0_reg, mg1_reg, mg2_reg, mg3_reg, mg4_reg;
    logic [DW-1:0]           mu0_reg, mu1_reg, mu2_reg, mu3_reg, mu4_reg;
    swiglu_pkg::sign_flags_t fl0_reg, fl1_reg, fl2_reg, fl3_reg, fl4_reg;
    logic [IW-1:0]           idx1_reg;
    logic [DW-2:0]           fr1_reg, fr2_reg;
    logic [SW-1:0]           t0_2_reg, dt2_reg, t0_3_reg;
    logic [IPW-1:0]          ip3_reg;
    logic [SW-1:0]           s4_reg;

    // next values
    logic [DW-1:0]           mg_next, mu_next;
    swiglu_pkg::sign_flags_t fl_next;
    logic [PW-1:0]           p_next;
    logic [IW-1:0]           idx_hi;
    logic [SW-1:0]           t0_next, t1_next;
    logic [IPW-1:0]          ip_next;
    logic [SW-1:0]           s_pos, s_next;

    // stage advance enables, each stage moves when empty or its successor moves
    logic en0, en1, en2, en3, en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    // magnitudes and signs
    always_comb
    begin
        mg_next          = gate[DW-1] ? (~gate + 1'b1) : gate;
        mu_next          = up[DW-1] ? (~up + 1'b1) : up;
        fl_next.gate_neg = gate[DW-1];
        fl_next.res_neg  = gate[DW-1] ^ up[DW-1];
    end

    // table position of the gate magnitude
    assign p_next = PW'(mg0_reg) * PW'(DEPTH);

    // table reads, upper point clamped at the last entry
    always_comb
    begin
        idx_hi  = (idx1_reg == LAST_IDX) ? idx1_reg : idx1_reg + 1'b1;
        t0_next = SIG_TABLE[int'(idx1_reg) * SW +: SW];
        t1_next = SIG_TABLE[int'(idx_hi) * SW +: SW];
    end

    // interpolation product
    assign ip_next = IPW'(dt2_reg) * IPW'(fr2_reg);

    // interpolated sigmoid, mirrored for a negative gate
    always_comb
    begin
        s_pos  = t0_3_reg + ip3_reg[IPW-1:DW-1];
        s_next = fl3_reg.gate_neg ? (SIG_ONE - s_pos) : s_pos;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            mg0_reg <= mg_next;
            mu0_reg <= mu_next;
            fl0_reg <= fl_next;
        end
        if (en1 && v0_reg)
        begin
            idx1_reg <= p_next[PW-1:DW-1];
            fr1_reg  <= p_next[DW-2:0];
            mg1_reg  <= mg0_reg;
            mu1_reg  <= mu0_reg;
            fl1_reg  <= fl0_reg;
        end
        if (en2 && v1_reg)
        begin
            t0_2_reg <= t0_next;
            dt2_reg  <= t1_next - t0_next;
            fr2_reg  <= fr1_reg;
            mg2_reg  <= mg1_reg;
            mu2_reg  <= mu1_reg;
            fl2_reg  <= fl1_reg;
        end
        if (en3 && v2_reg)
        begin
            t0_3_reg <= t0_2_reg;
            ip3_reg  <= ip_next;
            mg3_reg  <= mg2_reg;
            mu3_reg  <= mu2_reg;
            fl3_reg  <= fl2_reg;
        end
        if (en4 && v3_reg)
        begin
            s4_reg  <= s_next;
            mg4_reg <= mg3_reg;
            mu4_reg <= mu3_reg;
            fl4_reg <= fl3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign mag_gate  = mg4_reg;
    assign mag_up    = mu4_reg;
    assign sig       = s4_reg;
    assign flags     = fl4_reg;

endmodule

// ----- hw/rtl/swiglu_product.sv -----
// gate times sigmoid, times up, rounding and saturation stages
module swiglu_product #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [DATA_WIDTH-1:0]         mag_gate,
    input  logic [DATA_WIDTH-1:0]         mag_up,
    input  logic [FRAC_BITS:0]            sig,
    input  swiglu_pkg::sign_flags_t       flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  activation
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int SW = FB + 1;
    localparam int AW = DW + SW;
    localparam int BW = 2 * DW + 1;

    localparam logic [AW-1:0] HALF_A  = AW'(1) << (FB - 1);
    localparam logic [BW-1:0] HALF_B  = BW'(1) << (FB - 1);
    localparam logic [BW-1:0] POS_LIM = (BW'(1) << (DW - 1)) - 1'b1;
    localparam logic [BW-1:0] NEG_LIM = BW'(1) << (DW - 1);

    logic            v0_reg, v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]   araw0_reg;
    logic [DW-1:0]   a1_reg;
    logic [2*DW-1:0] p2_reg;
    logic [DW-1:0]   mu0_reg, mu1_reg;
    logic            neg0_reg, neg1_reg, neg2_reg;
    logic [DW-1:0]   res3_reg;

    logic [AW-1:0]   a_sum;
    logic [BW-1:0]   b_sum, b_mag;
    logic [DW-1:0]   res_next;

    logic en0, en1, en2, en3;

    // stage advance enables
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    // first product rounded half up on the magnitude
    assign a_sum = araw0_reg + HALF_A;

    // second product rounded, then clipped and signed
    always_comb
    begin
        b_sum = BW'(p2_reg) + HALF_B;
        b_mag = b_sum >> FB;
        if (neg2_reg)
        begin
            if (b_mag > NEG_LIM) b_mag = NEG_LIM;
            res_next = ~b_mag[DW-1:0] + 1'b1;
        end
        else
        begin
            if (b_mag > POS_LIM) b_mag = POS_LIM;
            res_next = b_mag[DW-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            araw0_reg <= AW'(mag_gate) * AW'(sig);
            mu0_reg   <= mag_up;
            neg0_reg  <= flags.res_neg;
        end
        if (en1 && v0_reg)
        begin
            a1_reg   <= a_sum[FB+DW-1:FB];
            mu1_reg  <= mu0_reg;
            neg1_reg <= neg0_reg;
        end
        if (en2 && v1_reg)
        begin
            p2_reg   <= (2*DW)'(a1_reg) * (2*DW)'(mu1_reg);
            neg2_reg <= neg1_reg;
        end
        if (en3 && v2_reg)
        begin
            res3_reg <= res_next;
        end
    end

    assign out_valid  = v3_reg;
    assign activation = res3_reg;

endmodule

// ----- hw/rtl/swiglu_activation_unit.sv -----
// top level of the swiglu gated silu activation unit
// Takes one gate/up pair per cycle while no stall holds the pipeline, and returns
// up * gate * sigmoid(gate) in signed fixed point (Q4.12 on 16 bits by default),
// saturated to the signed range. Each item passes nine register stages;
// throughput is one item per clock while the output side does not stall, set by
// the fully pipelined lookup and the multiplier stages. Sigmoid
// comes from a constant table of SIGMOID_LUT_DEPTH+1 points, computed during
// elaboration and read with linear interpolation; negative gates are mirrored.
// A stall empties bubbles first, so items are still taken while a result waits.
module swiglu_activation_unit #(
    parameter int DATA_WIDTH        = 16,
    parameter int FRAC_BITS         = 12,
    parameter int SIGMOID_LUT_DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // gate, up
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata   // activation
);

    localparam int DW       = DATA_WIDTH;
    localparam int OUT_BITS = ((DATA_WIDTH + 7) / 8) * 8;

    logic signed [DW-1:0]    gate, up;
    logic                    mid_valid, mid_ready;
    logic [DW-1:0]           mid_mag_gate, mid_mag_up;
    logic [FRAC_BITS:0]      mid_sig;
    swiglu_pkg::sign_flags_t mid_flags;
    logic [DW-1:0]           activation;

    // unpack input item
    assign gate = s_axis_tdata[DW-1:0];
    assign up   = s_axis_tdata[2*DW-1:DW];

    // sigmoid of gate
    swiglu_sigmoid #(
        .DATA_WIDTH        (DATA_WIDTH),
        .FRAC_BITS         (FRAC_BITS),
        .SIGMOID_LUT_DEPTH (SIGMOID_LUT_DEPTH)
    ) u_sigmoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .gate      (gate),
        .up        (up),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .mag_gate  (mid_mag_gate),
        .mag_up    (mid_mag_up),
        .sig       (mid_sig),
        .flags     (mid_flags)
    );

    // products, rounding and saturation
    swiglu_product #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .mag_gate   (mid_mag_gate),
        .mag_up     (mid_mag_up),
        .sig        (mid_sig),
        .flags      (mid_flags),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .activation (activation)
    );

    // pack output item
    assign m_axis_tdata = OUT_BITS'(activation);

endmodule

// ----- hw/rtl/swiglu_checker.sv -----
// port-level checker for the swiglu activation unit and its bind
module swiglu_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata    // activation
);

    logic [7:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_acc) - 8'(out_acc);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // input side is open whenever the output register can move
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input not ready while output side moves");

    // no result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 8'd0)
        else $error("result with no item in flight");

    // pipeline never holds more items than it has stages
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(swiglu_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind swiglu_activation_unit swiglu_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_swiglu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_top.sv -----
// testbench for the swiglu gated silu activation unit: random and corner gate/up items
`timescale 1ns / 100ps

module tb_top;

    localparam int DW    = 16;
    localparam int FB    = 12;
    localparam int DEPTH = 256;
    localparam int QF    = 28;

    localparam longint unsigned QF_ONE  = 64'd1 << QF;
    localparam longint unsigned QF_MASK = QF_ONE - 64'd1;
    localparam longint unsigned E_QF    = 64'd729683222;
    localparam longint unsigned FR_MASK = (64'd1 << (DW - 1)) - 64'd1;

    typedef struct packed {
        logic [DW-1:0] up;
        logic [DW-1:0] gate;
    } gu_pair_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata = '0;   // gate, up
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [15:0]   m_axis_tdata;        // activation

    // sigmoid points in unsigned Q.FB, built at time zero
    longint unsigned sigm_rom [0:DEPTH];

    gu_pair_t      stim_q[$];
    logic [DW-1:0] act_expected_q[$];

    logic          in_taken = 1'b0;
    int unsigned   in_gap = 0;
    int unsigned   in_calm = 0;
    int unsigned   out_gap = 0;
    int unsigned   out_calm = 0;
    gu_pair_t      next_pair;
    logic [DW-1:0] want_act;

    int            errors = 0;
    int            items_taken = 0;
    int            results_seen = 0;
    int            sat_seen = 0;
    int            neg_gate_seen = 0;

    swiglu_activation_unit #(
        .DATA_WIDTH       (DW),
        .FRAC_BITS        (FB),
        .SIGMOID_LUT_DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // truncated Q.28 product
    function automatic longint unsigned q28_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a >> QF) * b + (((a & QF_MASK) * b) >> QF);
    endfunction

    // expected activation for one gate/up pair
    function automatic logic [DW-1:0] swiglu_expect(input logic [DW-1:0] g,
                                                    input logic [DW-1:0] u);
        logic [DW-1:0]   neg_g;
        logic [DW-1:0]   neg_u;
        logic [DW-1:0]   res;
        longint unsigned mg;
        longint unsigned mu;
        longint unsigned p;
        longint unsigned idx;
        longint unsigned fr;
        longint unsigned s;
        longint unsigned a;
        longint unsigned b;
        neg_g = ~g + 1'b1;
        neg_u = ~u + 1'b1;
        mg    = 64'(g[DW-1] ? neg_g : g);
        mu    = 64'(u[DW-1] ? neg_u : u);
        // interpolated sigmoid of |gate|
        p   = mg * DEPTH;
        idx = p >> (DW - 1);
        fr  = p & FR_MASK;
        if (idx >= DEPTH)
            s = sigm_rom[DEPTH];
        else
            s = sigm_rom[idx] + (((sigm_rom[idx + 1] - sigm_rom[idx]) * fr) >> (DW - 1));
        // mirror for negative gate
        if (g[DW-1])
            s = (64'd1 << FB) - s;
        // two products, each rounded half away from zero on magnitudes
        a = (mg * s + (64'd1 << (FB - 1))) >> FB;
        b = (a * mu + (64'd1 << (FB - 1))) >> FB;
        // apply sign and saturate
        if (g[DW-1] != u[DW-1])
        begin
            if (b > (64'd1 << (DW - 1)))
                b = 64'd1 << (DW - 1);
            res = b[DW-1:0];
            return ~res + 1'b1;
        end
        if (b > FR_MASK)
            b = FR_MASK;
        return b[DW-1:0];
    endfunction

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_item(input logic [DW-1:0] g, input logic [DW-1:0] u);
        gu_pair_t pr;
        pr.gate = g;
        pr.up   = u;
        stim_q.push_back(pr);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (in_gap == 0 && stim_q.size() > 0)
                begin
                    next_pair = stim_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_pair.up, next_pair.gate};
                    in_gap = pick_gap(in_calm);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= $urandom;
                    if (in_gap > 0)
                        in_gap = in_gap - 1;
                end
            end
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                out_gap = out_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                out_gap = pick_gap(out_calm);
            end
        end
    end

    // monitor: check results, then record newly taken items
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (act_expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result activation=%h at %0t", m_axis_tdata, $time);
            end
            else
            begin
                want_act = act_expected_q.pop_front();
                if (want_act == 16'h7fff || want_act == 16'h8000)
                    sat_seen++;
                if (m_axis_tdata !== want_act)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("activation mismatch: expected %h got %h at %0t",
                                 want_act, m_axis_tdata, $time);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            items_taken++;
            if (s_axis_tdata[DW-1])
                neg_gate_seen++;
            act_expected_q.push_back(swiglu_expect(s_axis_tdata[DW-1:0],
                                                   s_axis_tdata[2*DW-1:DW]));
        end
    end

    // sigmoid table, stimulus, reset and end of run
    initial
    begin
        longint unsigned num;
        longint unsigned den;
        longint unsigned whole;
        longint unsigned rem;
        longint unsigned f;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned ex;
        longint unsigned pt;
        int unsigned     r;
        logic [DW-1:0]   g;
        logic [DW-1:0]   u;

        // sigmoid points: 1 - 1/(1 + e^x) in Q.FB, kept non-decreasing
        den = longint'(DEPTH) << FB;
        for (int i = 0; i <= DEPTH; i++)
        begin
            num   = longint'(i) << (DW - 1);
            whole = num / den;
            rem   = num % den;
            if (whole >= 20)
                pt = 64'd1 << FB;
            else
            begin
                f = 0;
                for (int k = 0; k < QF; k++)
                begin
                    rem = rem << 1;
                    f   = f << 1;
                    if (rem >= den)
                    begin
                        rem = rem - den;
                        f   = f | 64'd1;
                    end
                end
                term = QF_ONE;
                sum  = QF_ONE;
                for (int n = 1; n <= 16; n++)
                begin
                    term = q28_mul(term, f) / longint'(n);
                    sum  = sum + term;
                end
                ex = sum;
                for (longint unsigned k = 0; k < whole; k++)
                    ex = q28_mul(ex, E_QF);
                pt = (64'd1 << FB) -
                     (((64'd1 << (FB + QF)) + ((QF_ONE + ex) >> 1)) / (QF_ONE + ex));
            end
            if (i > 0 && pt < sigm_rom[i - 1])
                pt = sigm_rom[i - 1];
            sigm_rom[i] = pt;
        end

        // corner items: zero, extremes, saturation both ways, table nodes, mirroring
        queue_item(16'h0000, 16'h0000);
        queue_item(16'h7fff, 16'h7fff);
        queue_item(16'h7fff, 16'h8000);
        queue_item(16'h8000, 16'h7fff);
        queue_item(16'h8000, 16'h8000);
        queue_item(16'h0001, 16'h0001);
        queue_item(16'hffff, 16'hffff);
        queue_item(16'hffff, 16'h7fff);
        queue_item(16'h1000, 16'h1000);
        queue_item(16'hf000, 16'h1000);
        queue_item(16'h0080, 16'h1000);
        queue_item(16'h007f, 16'hf000);
        queue_item(16'h7f80, 16'd20000);
        queue_item(16'h8001, 16'd100);
        queue_item(16'h0000, 16'h8000);
        queue_item(16'h2000, 16'he000);
        queue_item(16'he000, 16'he000);
        queue_item(16'd20000, 16'h7fff);
        queue_item(16'd24000, -16'sd32000);
        queue_item(16'h4000, 16'h4000);
        queue_item(16'hc000, -16'sd12345);
        queue_item(16'h0800, 16'h1000);
        queue_item(16'hf800, 16'h1000);

        // random items over the full range, near the knee, and on table nodes
        for (int n = 0; n < 700; n++)
        begin
            r = $urandom_range(0, 99);
            u = DW'($urandom);
            if (r < 40)
                g = DW'($urandom);
            else if (r < 70)
                g = DW'($urandom_range(0, 24576) - 12288);
            else if (r < 85)
            begin
                g = DW'($urandom_range(0, 16384) - 8192);
                u = DW'($urandom_range(0, 16384) - 8192);
            end
            else
            begin
                g = DW'(($urandom_range(0, 255) << 7) + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    g = ~g + 1'b1;
            end
            queue_item(g, u);
        end

        // reset
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain
        while (stim_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (act_expected_q.size() > 0)
            @(posedge clk);
        repeat (swiglu_pkg::PIPE_DEPTH * 4) @(posedge clk);

        if (act_expected_q.size() != 0)
        begin
            errors += act_expected_q.size();
            $display("%0d results never arrived", act_expected_q.size());
        end
        $display("%0d gate/up items taken, %0d with negative gate, under random stalls",
                 items_taken, neg_gate_seen);
        $display("%0d activations checked, %0d of them at a saturation limit, %0d errors",
                 results_seen, sat_seen, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
